// ----- src/ntsb_pkg.sv -----
// Shared types and constants for the triangle snap builder.
// Used by ntsb_ctrl, ntsb_datapath and nav_triangle_snap_builder_top; depends on nothing.
package ntsb_pkg;

   localparam int MAX_CELLS  = 256;
   localparam int CELL_IDX_W = $clog2(MAX_CELLS);
   localparam int CELL_CNT_W = $clog2(MAX_CELLS + 1);
   localparam int COORD_W    = 24;
   localparam int RAY_W      = 16;
   localparam int RADIUS_W   = 32;
   localparam int DIST_W     = 51;

   localparam logic [RADIUS_W-1:0] SNAP_RADIUS_RESET = 32'd32113;

   localparam logic [2:0] FUNC_CLICK = 3'd0;
   localparam logic [2:0] FUNC_MOVE  = 3'd1;
   localparam logic [2:0] FUNC_DROP  = 3'd2;
   localparam logic [2:0] FUNC_UNDO  = 3'd3;
   localparam logic [2:0] FUNC_CLEAR = 3'd4;

   localparam logic [2:0] STAT_TAKEN  = 3'd0;
   localparam logic [2:0] STAT_STORED = 3'd1;
   localparam logic [2:0] STAT_DUP    = 3'd2;
   localparam logic [2:0] STAT_FULL   = 3'd3;
   localparam logic [2:0] STAT_OTHER  = 3'd4;

   localparam logic CSR_SNAP_RADIUS = 1'b0;
   localparam logic CSR_CELL_KIND   = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_MISC      = 4'd1,
      OP_SCAN_INIT = 4'd2,
      OP_SNAP_END  = 4'd3,
      OP_SORT      = 4'd4,
      OP_DIFF      = 4'd5,
      OP_MUL       = 4'd6,
      OP_CROSS     = 4'd7,
      OP_PART      = 4'd8,
      OP_SUM       = 4'd9,
      OP_ORIENT    = 4'd10,
      OP_COMMIT    = 4'd11,
      OP_OUT       = 4'd12
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
      logic   scan_en;
      logic   scan_dup;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       pend_two;
      logic       scan_done;
      logic       out_free;
   } stat_type;

endpackage

// ----- src/ntsb_datapath.sv -----
// Datapath of the triangle snap builder: cell memory, scan pipeline, orientation math,
// counters and the result register. Driven by ntsb_ctrl; depends on ntsb_pkg.
module ntsb_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ntsb_pkg::cmd_type                      cmd,
   output ntsb_pkg::stat_type                     stat,
   input  logic [2:0]                             req_func,
   input  logic signed [ntsb_pkg::COORD_W-1:0]    req_pos_x,
   input  logic signed [ntsb_pkg::COORD_W-1:0]    req_pos_y,
   input  logic signed [ntsb_pkg::COORD_W-1:0]    req_pos_z,
   input  logic signed [ntsb_pkg::RAY_W-1:0]      req_ray_x,
   input  logic signed [ntsb_pkg::RAY_W-1:0]      req_ray_y,
   input  logic signed [ntsb_pkg::RAY_W-1:0]      req_ray_z,
   input  logic                                   csr_wr_en,
   input  logic                                   csr_index,
   input  logic [ntsb_pkg::RADIUS_W-1:0]          csr_wr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ntsb_pkg::COORD_W-1:0]    rsp_snap_x,
   output logic signed [ntsb_pkg::COORD_W-1:0]    rsp_snap_y,
   output logic signed [ntsb_pkg::COORD_W-1:0]    rsp_snap_z,
   output logic [2:0]                             rsp_status,
   output logic [1:0]                             rsp_pending_count,
   output logic [ntsb_pkg::CELL_CNT_W-1:0]        rsp_cell_count
);

   // Configuration.
   logic [ntsb_pkg::RADIUS_W-1:0] radius_ff;
   logic                          kind_ff;

   // Current item.
   logic [2:0]                          func_ff;
   ntsb_pkg::vec_type                   pos_ff;
   logic signed [ntsb_pkg::RAY_W-1:0]   ray_ff [3];

   // Block state.
   ntsb_pkg::vec_type                   pend_ff [2];
   logic [1:0]                          pend_num_ff, pend_num_in;
   logic [ntsb_pkg::CELL_CNT_W-1:0]     stored_ff, stored_in;

   // Cell memory: one row holds the three corners of a cell.
   ntsb_pkg::vec_type [2:0]             cell_mem [ntsb_pkg::MAX_CELLS];
   logic                                kind_mem [ntsb_pkg::MAX_CELLS];
   logic                                mem_we;

   // Scan pipeline.
   logic [ntsb_pkg::CELL_CNT_W-1:0]     scan_cnt_ff;
   logic                                dup_mode_ff;
   logic                                issue;
   logic                                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   ntsb_pkg::vec_type [2:0]             row1_ff, row2_ff, row3_ff, row4_ff;
   logic signed [ntsb_pkg::COORD_W:0]   diff_ff [3][3];
   logic [48:0]                         sq_ff [3][3];
   logic [ntsb_pkg::DIST_W-1:0]         d_ff [3];
   logic [ntsb_pkg::DIST_W-1:0]         m_ff, m_in;
   ntsb_pkg::vec_type                   mv_ff, mv_in;
   logic                                found_ff;
   logic [ntsb_pkg::DIST_W-1:0]         best_ff;
   ntsb_pkg::vec_type                   best_v_ff;
   logic                                dup_ff;

   // Triangle math.
   ntsb_pkg::vec_type                   taken_ff, taken_in;
   ntsb_pkg::vec_type                   p_ff [3];
   ntsb_pkg::vec_type                   sorted [3];
   logic signed [ntsb_pkg::COORD_W:0]   ab_ff [3], bc_ff [3];
   logic signed [49:0]                  prod_ff [6];
   logic signed [50:0]                  cr_ff [3];
   logic signed [42:0]                  ph_ff [3];
   logic signed [40:0]                  pl_ff [3];
   logic signed [44:0]                  hs_ff;
   logic signed [42:0]                  ls_ff;
   logic signed [68:0]                  dot_total;

   // Result register.
   logic                                rsp_valid_ff;
   ntsb_pkg::vec_type                   out_v_ff;
   logic [2:0]                          out_stat_ff, stat_ff, stat_in;
   logic [1:0]                          out_pend_ff;
   logic [ntsb_pkg::CELL_CNT_W-1:0]     out_cells_ff;

   assign issue = cmd.scan_en && (scan_cnt_ff < stored_ff);

   assign stat.func      = func_ff;
   assign stat.pend_two  = pend_num_ff[1];
   assign stat.scan_done = !(scan_cnt_ff < stored_ff)
                           && !(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ntsb_pkg::SNAP_RADIUS_RESET;
         kind_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         if (csr_index == ntsb_pkg::CSR_SNAP_RADIUS) begin
            radius_ff <= csr_wr_data;
         end else begin
            kind_ff <= csr_wr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         pos_ff.x  <= req_pos_x;
         pos_ff.y  <= req_pos_y;
         pos_ff.z  <= req_pos_z;
         ray_ff[0] <= req_ray_x;
         ray_ff[1] <= req_ray_y;
         ray_ff[2] <= req_ray_z;
      end
   end

   // Memory: one write port, one registered read port.
   assign mem_we = (cmd.op == ntsb_pkg::OP_COMMIT) && !dup_ff
                   && (stored_ff < ntsb_pkg::CELL_CNT_W'(ntsb_pkg::MAX_CELLS));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[stored_ff[ntsb_pkg::CELL_IDX_W-1:0]] <= {p_ff[2], p_ff[1], p_ff[0]};
         kind_mem[stored_ff[ntsb_pkg::CELL_IDX_W-1:0]] <= kind_ff;
      end
      row1_ff <= cell_mem[scan_cnt_ff[ntsb_pkg::CELL_IDX_W-1:0]];
   end

   // Scan control and valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (cmd.op == ntsb_pkg::OP_SCAN_INIT) begin
            scan_cnt_ff <= '0;
         end else if (issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Distance pipeline: differences, squares, sums, per-cell minimum.
   always_comb begin
      m_in = (d_ff[1] < d_ff[0]) ? d_ff[1] : d_ff[0];
      if (d_ff[2] < m_in) begin
         m_in = d_ff[2];
      end
      if (d_ff[0] == m_in) begin
         mv_in = row4_ff[0];
      end else if (d_ff[1] == m_in) begin
         mv_in = row4_ff[1];
      end else begin
         mv_in = row4_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         diff_ff[k][0] <= {row1_ff[k].x[ntsb_pkg::COORD_W-1], row1_ff[k].x}
                          - {pos_ff.x[ntsb_pkg::COORD_W-1], pos_ff.x};
         diff_ff[k][1] <= {row1_ff[k].y[ntsb_pkg::COORD_W-1], row1_ff[k].y}
                          - {pos_ff.y[ntsb_pkg::COORD_W-1], pos_ff.y};
         diff_ff[k][2] <= {row1_ff[k].z[ntsb_pkg::COORD_W-1], row1_ff[k].z}
                          - {pos_ff.z[ntsb_pkg::COORD_W-1], pos_ff.z};
         for (int c = 0; c < 3; c++) begin
            sq_ff[k][c] <= 49'(diff_ff[k][c] * diff_ff[k][c]);
         end
         d_ff[k] <= ntsb_pkg::DIST_W'(sq_ff[k][0]) + ntsb_pkg::DIST_W'(sq_ff[k][1])
                    + ntsb_pkg::DIST_W'(sq_ff[k][2]);
      end
      row2_ff <= row1_ff;
      row3_ff <= row2_ff;
      row4_ff <= row3_ff;
      m_ff    <= m_in;
      mv_ff   <= mv_in;
   end

   // Running best and duplicate flag. A tie replaces the best, so later cells win.
   always_ff @(posedge clock) begin
      if (cmd.op == ntsb_pkg::OP_SCAN_INIT) begin
         dup_mode_ff <= cmd.scan_dup;
         found_ff    <= 1'b0;
         dup_ff      <= 1'b0;
      end else begin
         if (v5_ff && !dup_mode_ff && (!found_ff || m_ff <= best_ff)) begin
            found_ff  <= 1'b1;
            best_ff   <= m_ff;
            best_v_ff <= mv_ff;
         end
         if (v1_ff && dup_mode_ff && (row1_ff == {p_ff[2], p_ff[1], p_ff[0]})) begin
            dup_ff <= 1'b1;
         end
      end
   end

   // Selection sort on x, then the z-based reorder.
   always_comb begin
      ntsb_pkg::vec_type t [3];
      ntsb_pkg::vec_type tmp;
      logic [1:0]        mi;
      t[0] = pend_ff[0];
      t[1] = pend_ff[1];
      t[2] = taken_ff;
      mi = 2'd0;
      if (t[0].x > t[1].x) begin
         mi = 2'd1;
      end
      if (t[mi].x > t[2].x) begin
         mi = 2'd2;
      end
      tmp   = t[0];
      t[0]  = t[mi];
      t[mi] = tmp;
      if (t[1].x > t[2].x) begin
         tmp  = t[1];
         t[1] = t[2];
         t[2] = tmp;
      end
      sorted[0] = t[1];
      if (t[0].z < t[1].z) begin
         sorted[1] = t[2];
         sorted[2] = t[0];
      end else begin
         sorted[1] = t[0];
         sorted[2] = t[2];
      end
   end

   // The dot product is split at bit 24 of each normal component so that every
   // multiplier stays narrow; the recombined sum is exact.
   assign dot_total = (69'(hs_ff) <<< 24) + 69'(ls_ff);

   always_ff @(posedge clock) begin
      case (cmd.op)
         ntsb_pkg::OP_SORT: begin
            p_ff <= sorted;
         end
         ntsb_pkg::OP_DIFF: begin
            ab_ff[0] <= 25'(p_ff[1].x) - 25'(p_ff[0].x);
            ab_ff[1] <= 25'(p_ff[1].y) - 25'(p_ff[0].y);
            ab_ff[2] <= 25'(p_ff[1].z) - 25'(p_ff[0].z);
            bc_ff[0] <= 25'(p_ff[2].x) - 25'(p_ff[1].x);
            bc_ff[1] <= 25'(p_ff[2].y) - 25'(p_ff[1].y);
            bc_ff[2] <= 25'(p_ff[2].z) - 25'(p_ff[1].z);
         end
         ntsb_pkg::OP_MUL: begin
            prod_ff[0] <= ab_ff[1] * bc_ff[2];
            prod_ff[1] <= ab_ff[2] * bc_ff[1];
            prod_ff[2] <= ab_ff[2] * bc_ff[0];
            prod_ff[3] <= ab_ff[0] * bc_ff[2];
            prod_ff[4] <= ab_ff[0] * bc_ff[1];
            prod_ff[5] <= ab_ff[1] * bc_ff[0];
         end
         ntsb_pkg::OP_CROSS: begin
            cr_ff[0] <= 51'(prod_ff[0]) - 51'(prod_ff[1]);
            cr_ff[1] <= 51'(prod_ff[2]) - 51'(prod_ff[3]);
            cr_ff[2] <= 51'(prod_ff[4]) - 51'(prod_ff[5]);
         end
         ntsb_pkg::OP_PART: begin
            for (int i = 0; i < 3; i++) begin
               ph_ff[i] <= 43'($signed(cr_ff[i][50:24]) * ray_ff[i]);
               pl_ff[i] <= 41'($signed({1'b0, cr_ff[i][23:0]}) * ray_ff[i]);
            end
         end
         ntsb_pkg::OP_SUM: begin
            hs_ff <= 45'(ph_ff[0]) + 45'(ph_ff[1]) + 45'(ph_ff[2]);
            ls_ff <= 43'(pl_ff[0]) + 43'(pl_ff[1]) + 43'(pl_ff[2]);
         end
         ntsb_pkg::OP_ORIENT: begin
            // The normal faces the ray: swap first and last corner.
            if (!dot_total[68] && (dot_total != '0)) begin
               p_ff[0] <= p_ff[2];
               p_ff[2] <= p_ff[0];
            end
         end
         default: begin
         end
      endcase
   end

   // Taken point, status and counters.
   always_comb begin
      taken_in    = taken_ff;
      stat_in     = stat_ff;
      pend_num_in = pend_num_ff;
      stored_in   = stored_ff;
      case (cmd.op)
         ntsb_pkg::OP_MISC: begin
            stat_in  = ntsb_pkg::STAT_OTHER;
            taken_in = '0;
            case (func_ff)
               ntsb_pkg::FUNC_MOVE: begin
                  if (pend_num_ff != 2'd0) begin
                     taken_in = pos_ff;
                  end
               end
               ntsb_pkg::FUNC_DROP: begin
                  pend_num_in = 2'd0;
               end
               ntsb_pkg::FUNC_UNDO: begin
                  if (stored_ff != '0) begin
                     stored_in = stored_ff - 1'b1;
                  end
               end
               ntsb_pkg::FUNC_CLEAR: begin
                  stored_in = '0;
               end
               default: begin
               end
            endcase
         end
         ntsb_pkg::OP_SNAP_END: begin
            if (found_ff && best_ff <= ntsb_pkg::DIST_W'(radius_ff)) begin
               taken_in = best_v_ff;
            end else begin
               taken_in = pos_ff;
            end
            if (!pend_num_ff[1]) begin
               pend_num_in = pend_num_ff + 1'b1;
               stat_in     = ntsb_pkg::STAT_TAKEN;
            end
         end
         ntsb_pkg::OP_COMMIT: begin
            pend_num_in = 2'd0;
            if (dup_ff) begin
               stat_in = ntsb_pkg::STAT_DUP;
            end else if (!mem_we) begin
               stat_in = ntsb_pkg::STAT_FULL;
            end else begin
               stat_in   = ntsb_pkg::STAT_STORED;
               stored_in = stored_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      taken_ff <= taken_in;
      stat_ff  <= stat_in;
      if (cmd.op == ntsb_pkg::OP_MISC && func_ff == ntsb_pkg::FUNC_MOVE
          && pend_num_ff != 2'd0) begin
         pend_ff[pend_num_ff[1]] <= pos_ff;
      end else if (cmd.op == ntsb_pkg::OP_SNAP_END && !pend_num_ff[1]) begin
         pend_ff[pend_num_ff[0]] <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_num_ff <= 2'd0;
         stored_ff   <= '0;
      end else begin
         pend_num_ff <= pend_num_in;
         stored_ff   <= stored_in;
      end
   end

   // Result register: a new item may be taken while this beat waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == ntsb_pkg::OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ntsb_pkg::OP_OUT) begin
         out_v_ff     <= taken_ff;
         out_stat_ff  <= stat_ff;
         out_pend_ff  <= pend_num_ff;
         out_cells_ff <= stored_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_snap_x        = out_v_ff.x;
   assign rsp_snap_y        = out_v_ff.y;
   assign rsp_snap_z        = out_v_ff.z;
   assign rsp_status        = out_stat_ff;
   assign rsp_pending_count = out_pend_ff;
   assign rsp_cell_count    = out_cells_ff;

endmodule

// ----- src/ntsb_ctrl.sv -----
// Sequencer of the triangle snap builder: walks one item through decode, scans,
// triangle math and result load. Drives ntsb_datapath; depends on ntsb_pkg.
module ntsb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ntsb_pkg::stat_type stat,
   output ntsb_pkg::cmd_type  cmd
);

   typedef enum logic [15:0] {
      ST_IDLE      = 16'h0001,
      ST_DECODE    = 16'h0002,
      ST_MISC      = 16'h0004,
      ST_SNAP_SCAN = 16'h0008,
      ST_SNAP_END  = 16'h0010,
      ST_SORT      = 16'h0020,
      ST_DIFF      = 16'h0040,
      ST_MUL       = 16'h0080,
      ST_CROSS     = 16'h0100,
      ST_PART      = 16'h0200,
      ST_SUM       = 16'h0400,
      ST_ORIENT    = 16'h0800,
      ST_DUP_INIT  = 16'h1000,
      ST_DUP_SCAN  = 16'h2000,
      ST_COMMIT    = 16'h4000,
      ST_RESULT    = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.op       = ntsb_pkg::OP_NONE;
      cmd.load     = 1'b0;
      cmd.scan_en  = 1'b0;
      cmd.scan_dup = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.func == ntsb_pkg::FUNC_CLICK) begin
               cmd.op   = ntsb_pkg::OP_SCAN_INIT;
               state_in = ST_SNAP_SCAN;
            end else begin
               state_in = ST_MISC;
            end
         end
         ST_MISC: begin
            cmd.op   = ntsb_pkg::OP_MISC;
            state_in = ST_RESULT;
         end
         ST_SNAP_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_SNAP_END;
            end
         end
         ST_SNAP_END: begin
            cmd.op   = ntsb_pkg::OP_SNAP_END;
            state_in = stat.pend_two ? ST_SORT : ST_RESULT;
         end
         ST_SORT: begin
            cmd.op   = ntsb_pkg::OP_SORT;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = ntsb_pkg::OP_DIFF;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = ntsb_pkg::OP_MUL;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            cmd.op   = ntsb_pkg::OP_CROSS;
            state_in = ST_PART;
         end
         ST_PART: begin
            cmd.op   = ntsb_pkg::OP_PART;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = ntsb_pkg::OP_SUM;
            state_in = ST_ORIENT;
         end
         ST_ORIENT: begin
            cmd.op   = ntsb_pkg::OP_ORIENT;
            state_in = ST_DUP_INIT;
         end
         ST_DUP_INIT: begin
            cmd.op       = ntsb_pkg::OP_SCAN_INIT;
            cmd.scan_dup = 1'b1;
            state_in     = ST_DUP_SCAN;
         end
         ST_DUP_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.op   = ntsb_pkg::OP_COMMIT;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.op   = ntsb_pkg::OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/nav_triangle_snap_builder_top.sv -----
// Top level of the triangle snap builder: ties the sequencer to the datapath.
// Depends on ntsb_pkg, ntsb_ctrl and ntsb_datapath.

// Takes one request beat at a time and returns one response beat for it. A click
// scans every stored triangle for the snap point; a click that completes a triangle
// also runs the triangle math and a second scan for duplicates. The single read
// port of the cell memory delivers one stored triangle per cycle to the snap and
// duplicate scans. A new request is taken while the previous response beat still
// waits at the output.
module nav_triangle_snap_builder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_func,
   input  logic signed [ntsb_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [ntsb_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [ntsb_pkg::COORD_W-1:0] req_pos_z,
   input  logic signed [ntsb_pkg::RAY_W-1:0]   req_ray_x,
   input  logic signed [ntsb_pkg::RAY_W-1:0]   req_ray_y,
   input  logic signed [ntsb_pkg::RAY_W-1:0]   req_ray_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ntsb_pkg::COORD_W-1:0] rsp_snap_x,
   output logic signed [ntsb_pkg::COORD_W-1:0] rsp_snap_y,
   output logic signed [ntsb_pkg::COORD_W-1:0] rsp_snap_z,
   output logic [2:0]                          rsp_status,
   output logic [1:0]                          rsp_pending_count,
   output logic [ntsb_pkg::CELL_CNT_W-1:0]     rsp_cell_count,
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [ntsb_pkg::RADIUS_W-1:0]       csr_wr_data
);

   ntsb_pkg::cmd_type  cmd;
   ntsb_pkg::stat_type stat;

   ntsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ntsb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_ray_x         (req_ray_x),
      .req_ray_y         (req_ray_y),
      .req_ray_z         (req_ray_z),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_snap_x        (rsp_snap_x),
      .rsp_snap_y        (rsp_snap_y),
      .rsp_snap_z        (rsp_snap_z),
      .rsp_status        (rsp_status),
      .rsp_pending_count (rsp_pending_count),
      .rsp_cell_count    (rsp_cell_count)
   );

endmodule

// ----- tb/sv/nav_triangle_snap_builder_top_tb.sv -----
// Self-checking testbench for nav_triangle_snap_builder_top: clicks, moves, drops and
// table edits checked against an internal predictor. Depends on ntsb_pkg and the RTL.
module nav_triangle_snap_builder_top_tb;
   import ntsb_pkg::*;

   localparam int RUN_LIMIT = 4000000;

   typedef struct {
      logic [2:0]                func;
      logic signed [COORD_W-1:0] px, py, pz;
      logic signed [RAY_W-1:0]   rx, ry, rz;
   } click_item_type;

   typedef struct {
      logic [COORD_W-1:0]    sx, sy, sz;
      logic [2:0]            status;
      logic [1:0]            pend;
      logic [CELL_CNT_W-1:0] cells;
   } builder_rsp_type;

   typedef longint pt_type[3];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_func = '0;
   logic signed [COORD_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [RAY_W-1:0] req_ray_x = '0, req_ray_y = '0, req_ray_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_snap_x, rsp_snap_y, rsp_snap_z;
   logic [2:0] rsp_status;
   logic [1:0] rsp_pending_count;
   logic [CELL_CNT_W-1:0] rsp_cell_count;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_SNAP_RADIUS;
   logic [RADIUS_W-1:0] csr_wr_data = '0;

   nav_triangle_snap_builder_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   pt_type vert_store[MAX_CELLS*3];
   pt_type pend_pts[2];
   int unsigned pend_num = 0;
   int unsigned cell_num = 0;
   logic [RADIUS_W-1:0] radius_sq = SNAP_RADIUS_RESET;
   logic kind_reg = 1'b0;

   click_item_type  req_q[$];
   builder_rsp_type snap_results_q[$];
   click_item_type  cur_item;
   int  errors = 0;
   int  gap = 0;
   int  cycles = 0;
   bit  req_fire = 0;
   bit  rsp_hold = 0;

   function automatic int store_triangle(pt_type a, pt_type b, pt_type c, pt_type ray);
      pt_type t[3], p[3], tmp, ab, bc, cr;
      logic signed [127:0] acc, term;
      int mi;
      bit same;
      t[0] = a; t[1] = b; t[2] = c;
      for (int i = 0; i < 2; i++) begin
         mi = i;
         for (int j = i + 1; j < 3; j++)
            if (t[mi][0] > t[j][0]) mi = j;
         tmp = t[i]; t[i] = t[mi]; t[mi] = tmp;
      end
      p[0] = t[1];
      if (t[0][2] < t[1][2]) begin
         p[1] = t[2]; p[2] = t[0];
      end else begin
         p[1] = t[0]; p[2] = t[2];
      end
      for (int i = 0; i < 3; i++) begin
         ab[i] = p[1][i] - p[0][i];
         bc[i] = p[2][i] - p[1][i];
      end
      cr[0] = ab[1] * bc[2] - ab[2] * bc[1];
      cr[1] = ab[2] * bc[0] - ab[0] * bc[2];
      cr[2] = ab[0] * bc[1] - ab[1] * bc[0];
      // The dot product can exceed 64 bits, so it is summed at 128 bits.
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         term = cr[i];
         acc += term * 128'(signed'(ray[i]));
      end
      if (acc > 0) begin
         tmp = p[0]; p[0] = p[2]; p[2] = tmp;
      end
      for (int cl = 0; cl < cell_num; cl++) begin
         same = 1;
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               if (vert_store[cl*3+i][k] != p[i][k]) same = 0;
         if (same) return STAT_DUP;
      end
      if (cell_num >= MAX_CELLS) return STAT_FULL;
      for (int i = 0; i < 3; i++) vert_store[cell_num*3+i] = p[i];
      cell_num++;
      return STAT_STORED;
   endfunction

   function automatic builder_rsp_type predict_snap(click_item_type it);
      builder_rsp_type r;
      pt_type pos, ray, taken;
      longint d[3], m, best;
      bit found;
      int k;
      int unsigned st;
      pos = '{longint'(it.px), longint'(it.py), longint'(it.pz)};
      ray = '{longint'(it.rx), longint'(it.ry), longint'(it.rz)};
      taken = '{0, 0, 0};
      st = STAT_OTHER;
      case (it.func)
         FUNC_CLICK: begin
            found = 0;
            best = 0;
            taken = pos;
            for (int cl = 0; cl < cell_num; cl++) begin
               for (int v = 0; v < 3; v++) begin
                  d[v] = 0;
                  for (int a = 0; a < 3; a++)
                     d[v] += (vert_store[cl*3+v][a] - pos[a]) * (vert_store[cl*3+v][a] - pos[a]);
               end
               m = (d[0] < d[1]) ? d[0] : d[1];
               if (d[2] < m) m = d[2];
               if (!(found && best < m)) begin
                  found = 1;
                  best = m;
                  k = (d[0] == m) ? 0 : ((d[1] == m) ? 1 : 2);
                  taken = vert_store[cl*3+k];
               end
            end
            if (!found || best > longint'(radius_sq)) taken = pos;
            if (pend_num < 2) begin
               pend_pts[pend_num] = taken;
               pend_num++;
               st = STAT_TAKEN;
            end else begin
               st = store_triangle(pend_pts[0], pend_pts[1], taken, ray);
               pend_num = 0;
            end
         end
         FUNC_MOVE:
            if (pend_num > 0) begin
               pend_pts[pend_num-1] = pos;
               taken = pos;
            end
         FUNC_DROP: pend_num = 0;
         FUNC_UNDO: if (cell_num > 0) cell_num--;
         FUNC_CLEAR: cell_num = 0;
         default: ;
      endcase
      r.sx = taken[0][COORD_W-1:0];
      r.sy = taken[1][COORD_W-1:0];
      r.sz = taken[2][COORD_W-1:0];
      r.status = st[2:0];
      r.pend = pend_num[1:0];
      r.cells = cell_num[CELL_CNT_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   // Request side: handshake seen at the rising edge, payload changes at the falling edge.
   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      if (req_fire) snap_results_q = {snap_results_q, predict_snap(cur_item)};
   end

   always @(negedge clock) begin : drive_req
      bit nv;
      nv = req_valid;
      if (req_fire) nv = 0;
      if (!nv && !reset) begin
         if (gap > 0) gap--;
         else if (req_q.size() > 0) begin
            cur_item = req_q.pop_front();
            req_func  <= cur_item.func;
            req_pos_x <= cur_item.px;
            req_pos_y <= cur_item.py;
            req_pos_z <= cur_item.pz;
            req_ray_x <= cur_item.rx;
            req_ray_y <= cur_item.ry;
            req_ray_z <= cur_item.rz;
            nv = 1;
            gap = pick_gap();
         end
      end
      req_valid <= nv;
   end

   always @(negedge clock)
      rsp_ready <= !reset && !rsp_hold && (pick_gap() == 0);

   always @(posedge clock) begin : check_rsp
      builder_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (snap_results_q.size() == 0) begin
            $display("%0t: response beat with nothing expected, status %0d", $time, rsp_status);
            errors++;
         end else begin
            e = snap_results_q.pop_front();
            if (rsp_snap_x !== e.sx || rsp_snap_y !== e.sy || rsp_snap_z !== e.sz) begin
               $display("%0t: snap point expected %h %h %h, got %h %h %h", $time,
                        e.sx, e.sy, e.sz, rsp_snap_x, rsp_snap_y, rsp_snap_z);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d, got %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_pending_count !== e.pend) begin
               $display("%0t: pending count expected %0d, got %0d", $time, e.pend,
                        rsp_pending_count);
               errors++;
            end
            if (rsp_cell_count !== e.cells) begin
               $display("%0t: cell count expected %0d, got %0d", $time, e.cells,
                        rsp_cell_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_item(logic [2:0] f, longint x, longint y, longint z,
                            longint ax, longint ay, longint az);
      click_item_type it;
      while (req_q.size() > 1) @(negedge clock);
      it.func = f;
      it.px = x[COORD_W-1:0]; it.py = y[COORD_W-1:0]; it.pz = z[COORD_W-1:0];
      it.rx = ax[RAY_W-1:0];  it.ry = ay[RAY_W-1:0];  it.rz = az[RAY_W-1:0];
      req_q = {req_q, it};
   endtask

   task automatic wait_idle();
      while (req_q.size() > 0 || req_valid || snap_results_q.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [RADIUS_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SNAP_RADIUS) radius_sq = val;
      else kind_reg = val[0];
   endtask

   function automatic longint rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return longint'(signed'(24'($urandom())));
      return longint'($urandom_range(0, 4000)) - 2000;
   endfunction

   function automatic longint rand_ray();
      return longint'(signed'(16'($urandom())));
   endfunction

   task automatic random_click();
      longint x, y, z;
      pt_type v;
      int r;
      r = $urandom_range(0, 99);
      if (cell_num > 0 && r < 45) begin
         v = vert_store[$urandom_range(0, cell_num*3 - 1)];
         x = v[0] + $urandom_range(0, 360) - 180;
         y = v[1] + $urandom_range(0, 360) - 180;
         z = v[2] + $urandom_range(0, 360) - 180;
      end else begin
         x = rand_coord(); y = rand_coord(); z = rand_coord();
      end
      push_item(FUNC_CLICK, x, y, z, rand_ray(), rand_ray(), rand_ray());
   endtask

   task automatic random_phase(int n);
      int r, cl;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 5 && cell_num > 0 && pend_num == 0) begin
            // Re-enter corners of a stored cell exactly, each picked at random, to provoke a duplicate.
            cl = $urandom_range(0, cell_num - 1);
            for (int k = 0; k < 3; k++) begin
               r = $urandom_range(0, 2);
               push_item(FUNC_CLICK, vert_store[cl*3+r][0], vert_store[cl*3+r][1],
                         vert_store[cl*3+r][2], rand_ray(), rand_ray(), rand_ray());
            end
         end else if (r < 72) random_click();
         else if (r < 79) push_item(FUNC_MOVE, rand_coord(), rand_coord(), rand_coord(),
                                    rand_ray(), rand_ray(), rand_ray());
         else if (r < 84) push_item(FUNC_DROP, rand_coord(), 0, 0, 0, 0, 0);
         else if (r < 91) push_item(FUNC_UNDO, 0, rand_coord(), 0, 0, 0, 0);
         else if (r < 93) push_item(FUNC_CLEAR, 0, 0, rand_coord(), 0, 0, 0);
         else if (r < 96) push_item(3'($urandom_range(5, 7)), rand_coord(), rand_coord(),
                                    rand_coord(), rand_ray(), 0, 0);
         else random_click();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty-table operations, unused codes, extremes, snapping and a duplicate.
      push_item(FUNC_MOVE, 5, 6, 7, 0, 0, 0);
      push_item(FUNC_UNDO, 0, 0, 0, 0, 0, 0);
      push_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
      push_item(FUNC_DROP, 0, 0, 0, 0, 0, 0);
      push_item(3'd5, 1, 2, 3, 4, 5, 6);
      push_item(3'd6, 1, 2, 3, 4, 5, 6);
      push_item(3'd7, -1, -2, -3, -4, -5, -6);
      push_item(FUNC_CLICK, -8388608, -8388608, -8388608, 0, 0, 0);
      push_item(FUNC_CLICK, 8388607, 8388607, -8388608, 0, 0, 0);
      push_item(FUNC_CLICK, 8388607, -8388608, 8388607, 32767, -32768, 32767);
      push_item(FUNC_CLICK, 0, 0, 0, 0, 0, 0);
      push_item(FUNC_CLICK, 256, 0, 0, 0, 0, 0);
      push_item(FUNC_CLICK, 512, 0, 0, 0, 0, 0);
      push_item(FUNC_CLICK, 1, 1, 1, 0, 0, 0);
      push_item(FUNC_MOVE, 10, 10, 10, 0, 0, 0);
      push_item(FUNC_DROP, 0, 0, 0, 0, 0, 0);
      push_item(FUNC_CLICK, 512, 0, 0, 0, 0, 0);
      push_item(FUNC_CLICK, 0, 0, 0, 0, 0, 0);
      push_item(FUNC_CLICK, 256, 0, 0, -32768, 32767, -32768);
      push_item(FUNC_CLICK, 100, 0, 0, 0, 0, 0);
      push_item(FUNC_CLICK, 0, 300, 0, 0, 0, 0);
      push_item(FUNC_CLICK, 0, 0, 300, 16384, 16384, 16384);
      push_item(FUNC_UNDO, 0, 0, 0, 0, 0, 0);
      push_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
      wait_idle();

      write_csr(CSR_CELL_KIND, 32'd1);
      write_csr(CSR_SNAP_RADIUS, 32'hFFFF_FFFF);
      random_phase(60);
      wait_idle();

      // Exact-match snapping only, then fill the table past its capacity.
      write_csr(CSR_SNAP_RADIUS, 32'd0);
      write_csr(CSR_CELL_KIND, 32'd0);
      push_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
      push_item(FUNC_DROP, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < (MAX_CELLS + 3) * 3; i++)
         push_item(FUNC_CLICK, longint'(signed'(24'($urandom()))),
                   longint'(signed'(24'($urandom()))), longint'(signed'(24'($urandom()))),
                   rand_ray(), rand_ray(), rand_ray());
      wait_idle();
      for (int k = 0; k < 3; k++)
         push_item(FUNC_CLICK, vert_store[k][0], vert_store[k][1], vert_store[k][2], 0, 0, 0);
      push_item(FUNC_UNDO, 0, 0, 0, 0, 0, 0);
      wait_idle();

      write_csr(CSR_SNAP_RADIUS, $urandom());
      write_csr(CSR_CELL_KIND, 32'd1);
      push_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
      random_phase(80);
      wait_idle();

      write_csr(CSR_SNAP_RADIUS, SNAP_RADIUS_RESET);
      // Long receiver stall while requests keep coming, so the block backs up.
      fork
         begin
            repeat (300) @(posedge clock);
            rsp_hold = 1;
            repeat (2000) @(posedge clock);
            rsp_hold = 0;
         end
      join_none
      random_phase(80);
      wait_idle();
      while (rsp_hold) @(negedge clock);
      repeat (600) @(negedge clock);

      if (errors == 0 && snap_results_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
